/* sv/scco_pkg.sv */
// ----------------------------------------------------------------------------
// scco_pkg: shared widths and types for the swept circle contact offset
// Field widths of the external words and the default fraction width.
// ----------------------------------------------------------------------------
package scco_pkg;

	localparam int SCCO_FRAC_BITS = 8;
	localparam int POS_W          = 24;
	localparam int RAD_W          = 16;
	localparam int MOVE_W         = 16;

	// default geometry of the chain cells
	localparam int SQRT_IN_W      = 2 * MOVE_W;
	localparam int DIV_NUM_W      = MOVE_W + SCCO_FRAC_BITS;
	localparam int DIV_DEN_W      = MOVE_W;
	localparam int SIDE_W         = 8;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic        [RAD_W-1:0]  rad_t;
	typedef logic signed [MOVE_W-1:0] move_t;

endpackage

/* sv/swept_circle_contact_offset.sv */
// ----------------------------------------------------------------------------
// swept_circle_contact_offset: move of a circle clipped at first contact
// Overlap test at the end position, then the move is shortened along its
// direction to the contact distance. Fixed point, truncating.
// ----------------------------------------------------------------------------
//  channel  handshake              fields
//  in       in_valid / in_ready    target_x/y/radius, mover_x/y/radius, move_x/y
//  out      out_valid / out_ready  hit, allowed_x, allowed_y
//
// One word per cycle while the output is not stalled; the path is front stages, a
// 16-cell root for |move|, a (16 + FRAC_BITS)-cell divider for the direction,
// a 19-cell root for the contact term, and the scaling stages.
// Every stage holds its own valid; a stage loads whenever it is empty or its
// successor loads, so bubbles collapse and a stalled output only backs up.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module swept_circle_contact_offset #(
	parameter int FRAC_BITS = scco_pkg::SCCO_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  scco_pkg::pos_t   target_x,
	input  scco_pkg::pos_t   target_y,
	input  scco_pkg::rad_t   target_radius,
	input  scco_pkg::pos_t   mover_x,
	input  scco_pkg::pos_t   mover_y,
	input  scco_pkg::rad_t   mover_radius,
	input  scco_pkg::move_t  move_x,
	input  scco_pkg::move_t  move_y,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             hit,
	output scco_pkg::move_t  allowed_x,
	output scco_pkg::move_t  allowed_y
);
	import scco_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int QW    = F + 2;
	localparam int NUMW  = MOVE_W + F;
	localparam int LW    = POS_W + 2;
	localparam int LSQW  = 2 * LW;
	localparam int RW    = RAD_W + 1;
	localparam int RSQW  = 2 * RW;
	localparam int HLW   = RW + 1;
	localparam int VSQW  = 2 * MOVE_W;
	localparam int DW    = MOVE_W;
	localparam int LDW   = RW + 3;
	localparam int TW    = 2 * RW + 4;
	localparam int SRW   = TW / 2;
	localparam int FW    = LDW + 2;
	localparam int PW5   = HLW + QW;
	localparam int PW10  = FW + QW;
	localparam int NSQA  = VSQW / 2;
	localparam int NSQB  = TW / 2;
	localparam int SAW   = 1 + 2 * RSQW + 2 * HLW + 2 * MOVE_W;
	localparam int SDW   = SAW + DW + 2;
	localparam int SBW   = 1 + 2 * MOVE_W + DW + LDW + 2 * QW;
	localparam logic signed [PW5:0]    BIAS6  = (PW5+1)'((1 << F) - 1);
	localparam logic signed [PW10-1:0] BIAS11 = PW10'((1 << F) - 1);
	localparam logic signed [PW10-1:0] SMAX   = PW10'(32767);
	localparam logic signed [PW10-1:0] SMIN   = -PW10'(32768);

	// ---------------- stage 1: end position offset, radius sum
	logic                    v_s1, rdy_s1, rdy_s2;
	logic signed [LW-1:0]    lx_d, ly_d, lx_s1, ly_s1;
	logic        [RW-1:0]    r_d, r_s1;
	move_t                   vx_s1, vy_s1;

	assign lx_d   = target_x - mover_x - move_x;
	assign ly_d   = target_y - mover_y - move_y;
	assign r_d    = target_radius + mover_radius;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			lx_s1 <= lx_d;
			ly_s1 <= ly_d;
			r_s1  <= r_d;
			vx_s1 <= move_x;
			vy_s1 <= move_y;
		end
	end

	// ---------------- stage 2: squares
	logic                    v_s2, rdy_s3;
	logic signed [LSQW-1:0]  lxsq_d, lysq_d;
	logic        [LSQW-1:0]  lxsq_s2, lysq_s2;
	logic        [RSQW-1:0]  rsq_s2;
	logic signed [VSQW-1:0]  vxsq_d, vysq_d;
	logic        [VSQW-1:0]  vxsq_s2, vysq_s2;
	logic signed [LW-1:0]    lx_s2, ly_s2;
	move_t                   vx_s2, vy_s2;

	assign lxsq_d = lx_s1 * lx_s1;
	assign lysq_d = ly_s1 * ly_s1;
	assign vxsq_d = vx_s1 * vx_s1;
	assign vysq_d = vy_s1 * vy_s1;
	assign rdy_s2 = !v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			lxsq_s2 <= lxsq_d;
			lysq_s2 <= lysq_d;
			rsq_s2  <= r_s1 * r_s1;
			vxsq_s2 <= vxsq_d;
			vysq_s2 <= vysq_d;
			lx_s2   <= lx_s1;
			ly_s2   <= ly_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
		end
	end

	// ---------------- stage 3: overlap test, |move|^2
	logic                    v_s3;
	logic        [LSQW:0]    lsq_d;
	logic                    hit_s3;
	logic        [RSQW-1:0]  rsq_s3, lsq_s3;
	logic        [HLW-1:0]   lx_s3, ly_s3;
	logic        [VSQW-1:0]  vsq_s3;
	move_t                   vx_s3, vy_s3;
	logic                    sqa_rdy [NSQA+1];

	assign lsq_d  = lxsq_s2 + lysq_s2;
	assign rdy_s3 = !v_s3 || sqa_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			hit_s3 <= lsq_d <= (LSQW+1)'(rsq_s2);
			rsq_s3 <= rsq_s2;
			lsq_s3 <= lsq_d[RSQW-1:0];
			lx_s3  <= lx_s2[HLW-1:0];
			ly_s3  <= ly_s2[HLW-1:0];
			vsq_s3 <= vxsq_s2 + vysq_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
		end
	end

	// ---------------- root chain A: d = floor(sqrt(|move|^2))
	logic                    sqa_v    [NSQA+1];
	logic [VSQW-1:0]         sqa_val  [NSQA+1];
	logic [VSQW/2+1:0]       sqa_rem  [NSQA+1];
	logic [VSQW/2-1:0]       sqa_root [NSQA+1];
	logic [SAW-1:0]          sqa_side [NSQA+1];
	logic                    div_rdy  [NUMW+1];

	assign sqa_v[0]    = v_s3;
	assign sqa_val[0]  = vsq_s3;
	assign sqa_rem[0]  = '0;
	assign sqa_root[0] = '0;
	assign sqa_side[0] = {hit_s3, rsq_s3, lsq_s3, lx_s3, ly_s3, vx_s3, vy_s3};
	assign sqa_rdy[NSQA] = div_rdy[0];

	for (genvar i = 0; i < NSQA; i++) begin : g_sqa
		scco_sqrt_cell #(.NW(VSQW), .SW(SAW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sqa_v[i]),
			.in_ready (sqa_rdy[i]),
			.in_val   (sqa_val[i]),
			.in_rem   (sqa_rem[i]),
			.in_root  (sqa_root[i]),
			.in_side  (sqa_side[i]),
			.out_valid(sqa_v[i+1]),
			.out_ready(sqa_rdy[i+1]),
			.out_val  (sqa_val[i+1]),
			.out_rem  (sqa_rem[i+1]),
			.out_root (sqa_root[i+1]),
			.out_side (sqa_side[i+1])
		);
	end

	logic                    a_hit;
	logic [RSQW-1:0]         a_rsq, a_lsq;
	logic [HLW-1:0]          a_lx, a_ly;
	move_t                   a_vx, a_vy;
	logic [MOVE_W-1:0]       a_ax, a_ay;

	assign {a_hit, a_rsq, a_lsq, a_lx, a_ly, a_vx, a_vy} = sqa_side[NSQA];
	assign a_ax = a_vx[MOVE_W-1] ? MOVE_W'(-a_vx) : MOVE_W'(a_vx);
	assign a_ay = a_vy[MOVE_W-1] ? MOVE_W'(-a_vy) : MOVE_W'(a_vy);

	// ---------------- divider chain: |move_x| * 2^F / d and |move_y| * 2^F / d, one per lane
	logic                    div_v    [NUMW+1];
	logic [1:0][NUMW-1:0]    div_num  [NUMW+1];
	logic [1:0][DW-1:0]      div_rem  [NUMW+1];
	logic [1:0][NUMW-1:0]    div_quo  [NUMW+1];
	logic [DW-1:0]           div_den  [NUMW+1];
	logic [SDW-1:0]          div_side [NUMW+1];
	logic                    rdy_s5;

	assign div_v[0]    = sqa_v[NSQA];
	assign div_num[0]  = {{a_ay, F'(0)}, {a_ax, F'(0)}};
	assign div_rem[0]  = '0;
	assign div_quo[0]  = '0;
	assign div_den[0]  = sqa_root[NSQA];
	assign div_side[0] = {a_hit, a_rsq, a_lsq, a_lx, a_ly, a_vx, a_vy, sqa_root[NSQA],
		a_vx[MOVE_W-1], a_vy[MOVE_W-1]};
	assign div_rdy[NUMW] = rdy_s5;

	for (genvar i = 0; i < NUMW; i++) begin : g_div
		scco_div_cell #(.NW(NUMW), .DVW(DW), .SW(SDW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (div_v[i]),
			.in_ready (div_rdy[i]),
			.in_num   (div_num[i]),
			.in_rem   (div_rem[i]),
			.in_quo   (div_quo[i]),
			.in_div   (div_den[i]),
			.in_side  (div_side[i]),
			.out_valid(div_v[i+1]),
			.out_ready(div_rdy[i+1]),
			.out_num  (div_num[i+1]),
			.out_rem  (div_rem[i+1]),
			.out_quo  (div_quo[i+1]),
			.out_div  (div_den[i+1]),
			.out_side (div_side[i+1])
		);
	end

	logic                    b_hit, b_sx, b_sy;
	logic [RSQW-1:0]         b_rsq, b_lsq;
	logic signed [HLW-1:0]   b_lx, b_ly;
	move_t                   b_vx, b_vy;
	logic [DW-1:0]           b_d;
	logic signed [QW-1:0]    qxe, qye, b_dx, b_dy;

	assign {b_hit, b_rsq, b_lsq, b_lx, b_ly, b_vx, b_vy, b_d, b_sx, b_sy} = div_side[NUMW];
	assign qxe  = {1'b0, div_quo[NUMW][0][F:0]};
	assign qye  = {1'b0, div_quo[NUMW][1][F:0]};
	assign b_dx = b_sx ? -qxe : qxe;
	assign b_dy = b_sy ? -qye : qye;

	// ---------------- stage 5: L . dir products
	logic                    v_s5, rdy_s6;
	logic signed [PW5-1:0]   px_d, py_d, px_s5, py_s5;
	logic                    hit_s5;
	logic [RSQW-1:0]         rsq_s5, lsq_s5;
	move_t                   vx_s5, vy_s5;
	logic [DW-1:0]           d_s5;
	logic signed [QW-1:0]    dx_s5, dy_s5;

	assign px_d   = b_lx * b_dx;
	assign py_d   = b_ly * b_dy;
	assign rdy_s5 = !v_s5 || rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= div_v[NUMW];
		end
	end

	always_ff @(posedge clk) begin
		if (div_v[NUMW] && rdy_s5) begin
			px_s5  <= px_d;
			py_s5  <= py_d;
			hit_s5 <= b_hit;
			rsq_s5 <= b_rsq;
			lsq_s5 <= b_lsq;
			vx_s5  <= b_vx;
			vy_s5  <= b_vy;
			d_s5   <= b_d;
			dx_s5  <= b_dx;
			dy_s5  <= b_dy;
		end
	end

	// ---------------- stage 6: ldir, truncated toward zero
	logic                    v_s6, rdy_s7;
	logic signed [PW5:0]     dot_d, dotb_d, ldq_d;
	logic signed [LDW-1:0]   ldir_s6;
	logic                    hit_s6;
	logic [RSQW-1:0]         rsq_s6, lsq_s6;
	move_t                   vx_s6, vy_s6;
	logic [DW-1:0]           d_s6;
	logic signed [QW-1:0]    dx_s6, dy_s6;

	assign dot_d  = px_s5 + py_s5;
	assign dotb_d = dot_d[PW5] ? dot_d + BIAS6 : dot_d;
	assign ldq_d  = dotb_d >>> F;
	assign rdy_s6 = !v_s6 || rdy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s5 && rdy_s6) begin
			ldir_s6 <= ldq_d[LDW-1:0];
			hit_s6  <= hit_s5;
			rsq_s6  <= rsq_s5;
			lsq_s6  <= lsq_s5;
			vx_s6   <= vx_s5;
			vy_s6   <= vy_s5;
			d_s6    <= d_s5;
			dx_s6   <= dx_s5;
			dy_s6   <= dy_s5;
		end
	end

	// ---------------- stage 7: ldir^2
	logic                    v_s7, rdy_s8;
	logic signed [2*LDW-1:0] ldsq_d;
	logic [TW-1:0]           ldsq_s7;
	logic signed [LDW-1:0]   ldir_s7;
	logic                    hit_s7;
	logic [RSQW-1:0]         rsq_s7, lsq_s7;
	move_t                   vx_s7, vy_s7;
	logic [DW-1:0]           d_s7;
	logic signed [QW-1:0]    dx_s7, dy_s7;

	assign ldsq_d = ldir_s6 * ldir_s6;
	assign rdy_s7 = !v_s7 || rdy_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (rdy_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s6 && rdy_s7) begin
			ldsq_s7 <= ldsq_d[TW-1:0];
			ldir_s7 <= ldir_s6;
			hit_s7  <= hit_s6;
			rsq_s7  <= rsq_s6;
			lsq_s7  <= lsq_s6;
			vx_s7   <= vx_s6;
			vy_s7   <= vy_s6;
			d_s7    <= d_s6;
			dx_s7   <= dx_s6;
			dy_s7   <= dy_s6;
		end
	end

	// ---------------- stage 8: t = ldir^2 + R^2 - |L|^2, floored at zero
	logic                    v_s8;
	logic signed [TW+1:0]    tt_d;
	logic [TW-1:0]           t_s8;
	logic                    sqb_rdy [NSQB+1];

	assign tt_d   = $signed({2'b00, ldsq_s7}) + $signed((TW+2)'(rsq_s7))
		- $signed((TW+2)'(lsq_s7));
	assign rdy_s8 = !v_s8 || sqb_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (rdy_s8) begin
			v_s8 <= v_s7;
		end
	end

	logic [SBW-1:0]          side_s8;

	always_ff @(posedge clk) begin
		if (v_s7 && rdy_s8) begin
			t_s8    <= tt_d[TW+1] ? '0 : tt_d[TW-1:0];
			side_s8 <= {hit_s7, vx_s7, vy_s7, d_s7, ldir_s7, dx_s7, dy_s7};
		end
	end

	// ---------------- root chain B: s = floor(sqrt(t))
	logic                    sqb_v    [NSQB+1];
	logic [TW-1:0]           sqb_val  [NSQB+1];
	logic [TW/2+1:0]         sqb_rem  [NSQB+1];
	logic [TW/2-1:0]         sqb_root [NSQB+1];
	logic [SBW-1:0]          sqb_side [NSQB+1];
	logic                    rdy_s9;

	assign sqb_v[0]    = v_s8;
	assign sqb_val[0]  = t_s8;
	assign sqb_rem[0]  = '0;
	assign sqb_root[0] = '0;
	assign sqb_side[0] = side_s8;
	assign sqb_rdy[NSQB] = rdy_s9;

	for (genvar i = 0; i < NSQB; i++) begin : g_sqb
		scco_sqrt_cell #(.NW(TW), .SW(SBW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sqb_v[i]),
			.in_ready (sqb_rdy[i]),
			.in_val   (sqb_val[i]),
			.in_rem   (sqb_rem[i]),
			.in_root  (sqb_root[i]),
			.in_side  (sqb_side[i]),
			.out_valid(sqb_v[i+1]),
			.out_ready(sqb_rdy[i+1]),
			.out_val  (sqb_val[i+1]),
			.out_rem  (sqb_rem[i+1]),
			.out_root (sqb_root[i+1]),
			.out_side (sqb_side[i+1])
		);
	end

	logic                    c_hit;
	move_t                   c_vx, c_vy;
	logic [DW-1:0]           c_d;
	logic signed [LDW-1:0]   c_ldir;
	logic signed [QW-1:0]    c_dx, c_dy;
	logic [SRW-1:0]          c_s;

	assign {c_hit, c_vx, c_vy, c_d, c_ldir, c_dx, c_dy} = sqb_side[NSQB];
	assign c_s = sqb_root[NSQB];

	// ---------------- stage 9: contact distance, clamped at zero
	logic                    v_s9, rdy_s10;
	logic signed [FW-1:0]    fr_d;
	logic [FW-2:0]           frac_s9;
	logic                    hit_s9, dz_s9;
	move_t                   vx_s9, vy_s9;
	logic signed [QW-1:0]    dx_s9, dy_s9;

	assign fr_d   = $signed(FW'(c_d)) + c_ldir - $signed(FW'(c_s));
	assign rdy_s9 = !v_s9 || rdy_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (rdy_s9) begin
			v_s9 <= sqb_v[NSQB];
		end
	end

	always_ff @(posedge clk) begin
		if (sqb_v[NSQB] && rdy_s9) begin
			frac_s9 <= fr_d[FW-1] ? '0 : fr_d[FW-2:0];
			hit_s9  <= c_hit;
			dz_s9   <= c_d == '0;
			vx_s9   <= c_vx;
			vy_s9   <= c_vy;
			dx_s9   <= c_dx;
			dy_s9   <= c_dy;
		end
	end

	// ---------------- stage 10: distance times direction
	logic                    v_s10, rdy_s11;
	logic signed [PW10-1:0]  mx_d, my_d, mx_s10, my_s10;
	logic                    hit_s10, dz_s10;
	move_t                   vx_s10, vy_s10;

	assign mx_d    = $signed({1'b0, frac_s9}) * dx_s9;
	assign my_d    = $signed({1'b0, frac_s9}) * dy_s9;
	assign rdy_s10 = !v_s10 || rdy_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (rdy_s10) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s9 && rdy_s10) begin
			mx_s10  <= mx_d;
			my_s10  <= my_d;
			hit_s10 <= hit_s9;
			dz_s10  <= dz_s9;
			vx_s10  <= vx_s9;
			vy_s10  <= vy_s9;
		end
	end

	// ---------------- stage 11: scale down, saturate, select; output register
	logic                    v_s11;
	logic signed [PW10-1:0]  mxb_d, myb_d, ax_d, ay_d;
	move_t                   sx_d, sy_d;
	logic                    hit_s11;
	move_t                   ax_s11, ay_s11;

	assign mxb_d = mx_s10[PW10-1] ? mx_s10 + BIAS11 : mx_s10;
	assign myb_d = my_s10[PW10-1] ? my_s10 + BIAS11 : my_s10;
	assign ax_d  = mxb_d >>> F;
	assign ay_d  = myb_d >>> F;

	always_comb begin
		priority if (ax_d > SMAX) sx_d = MOVE_W'(SMAX);
		else if (ax_d < SMIN)     sx_d = MOVE_W'(SMIN);
		else                      sx_d = ax_d[MOVE_W-1:0];
		priority if (ay_d > SMAX) sy_d = MOVE_W'(SMAX);
		else if (ay_d < SMIN)     sy_d = MOVE_W'(SMIN);
		else                      sy_d = ay_d[MOVE_W-1:0];
	end

	assign rdy_s11 = !v_s11 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (rdy_s11) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s10 && rdy_s11) begin
			hit_s11 <= hit_s10;
			priority if (!hit_s10) begin
				ax_s11 <= vx_s10;
				ay_s11 <= vy_s10;
			end else if (dz_s10) begin
				ax_s11 <= '0;
				ay_s11 <= '0;
			end else begin
				ax_s11 <= sx_d;
				ay_s11 <= sy_d;
			end
		end
	end

	assign out_valid = v_s11;
	assign hit       = hit_s11;
	assign allowed_x = ax_s11;
	assign allowed_y = ay_s11;

endmodule

/* sv/scco_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// scco_sqrt_cell: one digit of a pipelined integer square root
// Takes two radicand bits per cell, keeps the partial root and remainder,
// and carries a side vector along with the word.
// ----------------------------------------------------------------------------
module scco_sqrt_cell #(
	parameter int NW = scco_pkg::SQRT_IN_W,
	parameter int SW = scco_pkg::SIDE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NW-1:0]     in_val,
	input  logic [NW/2+1:0]   in_rem,
	input  logic [NW/2-1:0]   in_root,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NW-1:0]     out_val,
	output logic [NW/2+1:0]   out_rem,
	output logic [NW/2-1:0]   out_root,
	output logic [SW-1:0]     out_side
);
	import scco_pkg::*;

	localparam int HW = NW / 2;
	localparam int RW = HW + 2;

	logic          vld_q;
	logic [RW+1:0] rem2;
	logic [RW+1:0] trial;
	logic          ge;
	logic [RW+1:0] diff;

	assign rem2  = {in_rem, in_val[NW-1 -: 2]};
	assign trial = {2'b00, in_root, 2'b01};
	assign ge    = rem2 >= trial;
	assign diff  = rem2 - trial;

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_val  <= {in_val[NW-3:0], 2'b00};
			out_rem  <= ge ? diff[RW-1:0] : rem2[RW-1:0];
			out_root <= {in_root[HW-2:0], ge};
			out_side <= in_side;
		end
	end

endmodule

/* sv/scco_div_cell.sv */
// ----------------------------------------------------------------------------
// scco_div_cell: one quotient bit of a two-lane restoring divider
// Both lanes share the divisor; the side vector travels with the word.
// ----------------------------------------------------------------------------
module scco_div_cell #(
	parameter int NW  = scco_pkg::DIV_NUM_W,
	parameter int DVW = scco_pkg::DIV_DEN_W,
	parameter int SW  = scco_pkg::SIDE_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0][NW-1:0]   in_num,
	input  logic [1:0][DVW-1:0]  in_rem,
	input  logic [1:0][NW-1:0]   in_quo,
	input  logic [DVW-1:0]       in_div,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0][NW-1:0]   out_num,
	output logic [1:0][DVW-1:0]  out_rem,
	output logic [1:0][NW-1:0]   out_quo,
	output logic [DVW-1:0]       out_div,
	output logic [SW-1:0]        out_side
);
	import scco_pkg::*;

	logic                vld_q;
	logic [1:0][DVW:0]   r2;
	logic [1:0][DVW:0]   diff;
	logic [1:0]          ge;
	logic [1:0][DVW-1:0] rem_n;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			r2[k]    = {in_rem[k], in_num[k][NW-1]};
			diff[k]  = r2[k] - {1'b0, in_div};
			ge[k]    = r2[k] >= {1'b0, in_div};
			rem_n[k] = ge[k] ? diff[k][DVW-1:0] : r2[k][DVW-1:0];
		end
	end

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int k = 0; k < 2; k++) begin
				out_num[k] <= {in_num[k][NW-2:0], 1'b0};
				out_rem[k] <= rem_n[k];
				out_quo[k] <= {in_quo[k][NW-2:0], ge[k]};
			end
			out_div  <= in_div;
			out_side <= in_side;
		end
	end

endmodule

/* tb/scco_contact_checker.sv */
// ----------------------------------------------------------------------------
// scco_contact_checker: predicts and checks swept circle contact results
// Watches both channels, computes the expected clipped move for every
// accepted input word and compares it with the oldest pending result word.
// ----------------------------------------------------------------------------
module scco_contact_checker #(
	parameter int FRAC_BITS = scco_pkg::SCCO_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  scco_pkg::pos_t   target_x,
	input  scco_pkg::pos_t   target_y,
	input  scco_pkg::rad_t   target_radius,
	input  scco_pkg::pos_t   mover_x,
	input  scco_pkg::pos_t   mover_y,
	input  scco_pkg::rad_t   mover_radius,
	input  scco_pkg::move_t  move_x,
	input  scco_pkg::move_t  move_y,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             hit,
	input  scco_pkg::move_t  allowed_x,
	input  scco_pkg::move_t  allowed_y,
	output int               fail_count,
	output int               pending_count
);
	import scco_pkg::*;

	localparam int EXP_DEPTH = 4096;

	typedef struct packed {
		logic  hit;
		move_t ax;
		move_t ay;
	} contact_t;

	// expected words, written at wr_idx and consumed at rd_idx
	contact_t exp_mem [EXP_DEPTH];
	int       wr_idx, rd_idx;

	function automatic longint root_floor(longint v);
		longint res, rem, bit_v;
		res = 0;
		rem = v;
		bit_v = 64'sd1 <<< 62;
		while (bit_v > rem)
			bit_v = bit_v >>> 2;
		while (bit_v != 0) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >>> 1) + bit_v;
			end else begin
				res = res >>> 1;
			end
			bit_v = bit_v >>> 2;
		end
		return res;
	endfunction

	function automatic move_t clip16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return move_t'(v);
	endfunction

	function automatic contact_t clip_move(pos_t tx, pos_t ty, rad_t tr, pos_t mx, pos_t my,
			rad_t mr, move_t vx, move_t vy);
		longint one, lx, ly, r, rsq, lsq, d, dx, dy, ldir, t, s, frac;
		contact_t c;
		one = 64'sd1 <<< FRAC_BITS;
		lx = longint'(tx) - (longint'(mx) + longint'(vx));
		ly = longint'(ty) - (longint'(my) + longint'(vy));
		r = longint'(tr) + longint'(mr);
		rsq = r * r;
		lsq = lx * lx + ly * ly;
		if (lsq > rsq) begin
			c.hit = 1'b0;
			c.ax = vx;
			c.ay = vy;
			return c;
		end
		c.hit = 1'b1;
		d = root_floor(longint'(vx) * vx + longint'(vy) * vy);
		if (d == 0) begin
			c.ax = '0;
			c.ay = '0;
			return c;
		end
		dx = (longint'(vx) * one) / d;
		dy = (longint'(vy) * one) / d;
		ldir = (lx * dx + ly * dy) / one;
		t = ldir * ldir + rsq - lsq;
		if (t < 0)
			t = 0;
		s = root_floor(t);
		frac = d + ldir - s;
		if (frac < 0)
			frac = 0;
		c.ax = clip16((frac * dx) / one);
		c.ay = clip16((frac * dy) / one);
		return c;
	endfunction

	assign pending_count = wr_idx - rd_idx;

	always @(posedge clk or negedge arst_n) begin
		contact_t exp_c;
		if (!arst_n) begin
			fail_count <= 0;
			wr_idx     <= 0;
			rd_idx     <= 0;
		end else begin
			if (in_valid && in_ready) begin
				exp_mem[wr_idx % EXP_DEPTH] <= clip_move(target_x, target_y,
					target_radius, mover_x, mover_y, mover_radius, move_x, move_y);
				wr_idx <= wr_idx + 1;
			end
			if (out_valid && out_ready) begin
				if (wr_idx == rd_idx) begin
					$display("%0t: unexpected word hit=%0d x=%0d y=%0d", $time, hit,
						allowed_x, allowed_y);
					fail_count <= fail_count + 1;
				end else begin
					exp_c = exp_mem[rd_idx % EXP_DEPTH];
					rd_idx <= rd_idx + 1;
					if (exp_c.hit !== hit || exp_c.ax !== allowed_x
							|| exp_c.ay !== allowed_y) begin
						$display({"%0t: mismatch expected hit=%0d x=%0d y=%0d",
							" actual hit=%0d x=%0d y=%0d"}, $time, exp_c.hit,
							exp_c.ax, exp_c.ay, hit, allowed_x, allowed_y);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/tb_swept_circle_contact_offset.sv */
// ----------------------------------------------------------------------------
// tb_swept_circle_contact_offset: stimulus and verdict
// Directed corner words, then random near-contact and random words under
// several sender and receiver idling phases; the checker does the compare.
// ----------------------------------------------------------------------------
module tb_swept_circle_contact_offset;
	import scco_pkg::*;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	pos_t  target_x = '0, target_y = '0, mover_x = '0, mover_y = '0;
	rad_t  target_radius = '0, mover_radius = '0;
	move_t move_x = '0, move_y = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	logic  hit;
	move_t allowed_x, allowed_y;
	int    fail_count, pending_count;
	int    send_idle_pct = 0, recv_stall_pct = 0;

	always #1 clk = ~clk;

	swept_circle_contact_offset i_dut (.*);

	scco_contact_checker i_checker (.*);

	always @(posedge clk)
		out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);

	task automatic send_word(pos_t tx, pos_t ty, rad_t tr, pos_t mx, pos_t my, rad_t mr,
			move_t vx, move_t vy);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_x <= tx; target_y <= ty; target_radius <= tr;
		mover_x <= mx; mover_y <= my; mover_radius <= mr;
		move_x <= vx; move_y <= vy;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random(int n);
		pos_t  mx, my;
		move_t vx, vy;
		rad_t  tr, mr;
		int    k;
		for (int i = 0; i < n; i++) begin
			k = int'($urandom_range(9));
			mx = pos_t'($urandom); my = pos_t'($urandom);
			tr = rad_t'($urandom); mr = rad_t'($urandom);
			vx = move_t'($urandom); vy = move_t'($urandom);
			if (k < 2) begin
				send_word(pos_t'($urandom), pos_t'($urandom), tr, mx, my, mr, vx, vy);
			end else begin
				// small sizes keep the target near the path so contacts happen
				if (k < 6) begin
					vx = move_t'(int'($urandom_range(4095)) - 2048);
					vy = move_t'(int'($urandom_range(4095)) - 2048);
					tr = rad_t'($urandom_range(2047)); mr = rad_t'($urandom_range(2047));
				end
				send_word(pos_t'(int'(mx) + int'(vx) + int'($urandom_range(8191)) - 4096),
					pos_t'(int'(my) + int'(vy) + int'($urandom_range(8191)) - 4096),
					tr, mx, my, mr, vx, vy);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: no overlap, zero move on hit, contact behind start, saturation
		send_word(24'sd100000, 0, 256, 0, 0, 256, 16'sd1000, 16'sd0);
		send_word(0, 0, 256, 0, 0, 256, 0, 0);
		send_word(0, 0, 16'hffff, 0, 0, 16'hffff, 0, 0);
		send_word(0, 0, 1000, 0, 0, 1000, 16'sd500, 16'sd500);
		send_word(0, 0, 256, -24'sd600, 0, 256, 16'sd400, 0);
		send_word(24'sd20000, 0, 16'hffff, 0, 0, 16'hffff, 16'sh7fff, 16'sh7fff);
		send_word(-24'sd20000, 0, 16'hffff, 0, 0, 16'hffff, 16'sh8000, 16'sh8000);
		send_word(0, 0, 16'hffff, 0, 0, 16'hffff, 16'sh8000, 16'sh7fff);
		send_word(24'sh7fffff, 24'sh7fffff, 16'hffff, 24'sh7fffff, 24'sh7fffff, 16'hffff,
			16'sh8000, 16'sh8000);
		send_word(24'sh800000, 24'sh800000, 16'hffff, 24'sh800000, 24'sh800000, 16'hffff,
			16'sh7fff, 16'sh7fff);
		send_word(24'sh7fffff, 24'sh800000, 0, 24'sh800000, 24'sh7fffff, 0, 16'sh7fff, -1);
		send_word(0, 0, 0, 16'sd1, 16'sd1, 0, -16'sd1, -16'sd1);
		send_word(0, 24'sd300, 128, 0, 0, 128, 0, 16'sd300);
		send_word(24'sd300, 24'sd10, 100, 0, 0, 100, 16'sd400, 16'sd3);
		send_random(220);
		send_idle_pct = 77;
		send_random(220);
		send_idle_pct = 0; recv_stall_pct = 77;
		send_random(220);
		send_idle_pct = 31; recv_stall_pct = 31;
		send_random(220);
		recv_stall_pct = 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
sv/scco_pkg.sv
sv/scco_sqrt_cell.sv
sv/scco_div_cell.sv
sv/swept_circle_contact_offset.sv
tb/scco_contact_checker.sv
tb/tb_swept_circle_contact_offset.sv
